@@ src/enms_pkg.sv @@
// enms_pkg: widths, limits and angle sector helper for edge non-maximum suppression
`default_nettype none

package enms_pkg;

  localparam int MaxWidth = 1024;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int CfgW     = 11;
  localparam int MagW     = 8;
  localparam int AngW     = 12;

  localparam logic [CfgW-1:0] FrameWidthRst = CfgW'(640);
  localparam int              MinWidth      = 3;

  // angle bounds in tenths of a degree
  localparam logic signed [AngW:0] AngHalf = (AngW+1)'(1800);
  localparam logic signed [AngW:0] AngFull = (AngW+1)'(3600);
  localparam logic signed [AngW:0] Bnd22   = (AngW+1)'(225);
  localparam logic signed [AngW:0] Bnd67   = (AngW+1)'(675);
  localparam logic signed [AngW:0] Bnd112  = (AngW+1)'(1125);
  localparam logic signed [AngW:0] Bnd157  = (AngW+1)'(1575);

  typedef enum logic [1:0] {
    SecHoriz,
    SecDiagR,
    SecVert,
    SecDiagL
  } sector_e;

  typedef logic [MagW-1:0] mag_t;
  typedef logic [AngW-1:0] ang_t;

  // fold to (-180,180] and bin into one of four directions
  function automatic sector_e angle_sector(input ang_t ang);
    logic signed [AngW:0] a;
    sector_e sec;
    a = signed'({1'b0, ang});
    if (a > AngHalf) begin
      a = a - AngFull;
    end
    if ((a > -Bnd22 && a <= Bnd22) || a > Bnd157 || a <= -Bnd157) begin
      sec = SecHoriz;
    end else if ((a > -Bnd67 && a <= -Bnd22) || (a > Bnd112 && a <= Bnd157)) begin
      sec = SecDiagR;
    end else if ((a > -Bnd112 && a <= -Bnd67) || (a > Bnd67 && a <= Bnd112)) begin
      sec = SecVert;
    end else begin
      sec = SecDiagL;
    end
    return sec;
  endfunction

endpackage

`default_nettype wire

@@ src/edge_non_maximum_suppression.sv @@
// edge_non_maximum_suppression: streaming 3x3 directional non-maximum suppression
//
//   channel | handshake                | payload
//   --------+--------------------------+----------------------------------------------
//   cfg     | cfg_we_i                 | cfg_wdata_i (frame width)
//   in      | in_valid_i / in_ready_o  | grad_magnitude_i, grad_angle_i, frame_start_i
//   res     | res_valid_o / res_ready_i| kept_magnitude_o, out_valid_o
//
// one pixel per clock sustained; each result passes the first stage and then the output register.
// the first stage holds the pixel and the registered line store reads, the second
// shifts the window, runs the direction test, writes the line stores and loads the
// output register. every accepted pixel gives one result transfer.
// in_ready_o drops while the line stores are cleared and while both stages are full
// and res_ready_i is low.
// reset brings frame width to 640 and position to row 0, column 0; the line stores are
// then cleared one entry per cycle, all MaxWidth (1024) entries, with in_ready_o low.
`default_nettype none

module edge_non_maximum_suppression
  import enms_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CfgW-1:0]  cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [MagW-1:0]  grad_magnitude_i,
  input  wire logic [AngW-1:0]  grad_angle_i,
  input  wire logic             frame_start_i,
  output logic                  res_valid_o,
  input  wire logic             res_ready_i,
  output logic [MagW-1:0]       kept_magnitude_o,
  output logic                  out_valid_o
);

  logic [CfgW-1:0] cfg_q;
  logic [ColW:0]   eff_width;

  logic [ColW-1:0] col_q, col_d;
  logic [1:0]      row_q, row_d;
  logic [ColW-1:0] cur_col;
  logic [1:0]      cur_row;
  logic [ColW:0]   col_inc;

  logic            in_fire, s1_fire, out_free;

  // line store clearing after reset
  logic            clr_q;
  logic [ColW-1:0] clr_addr_q;

  // first stage
  logic            s1_v_q;
  mag_t            s1_mag_q;
  ang_t            s1_ang_q;
  logic [ColW-1:0] s1_col_q;
  logic            s1_center_q, s1_border_q;
  mag_t            prev_rd_q, older_rd_q;
  ang_t            angr_rd_q;

  // line stores
  mag_t            prev_mem  [MaxWidth];
  mag_t            older_mem [MaxWidth];
  ang_t            ang_mem   [MaxWidth];

  // window and center angle
  mag_t            win_q [9];
  mag_t            win_d [9];
  ang_t            center_ang_q;
  sector_e         sector;
  mag_t            nb_a, nb_b, kept;

  // output register
  logic            ov_q;
  mag_t            kept_q;
  logic            outv_q;

  always_comb begin
    if (int'(cfg_q) < MinWidth) begin
      eff_width = (ColW+1)'(MinWidth);
    end else if (int'(cfg_q) > MaxWidth) begin
      eff_width = (ColW+1)'(MaxWidth);
    end else begin
      eff_width = (ColW+1)'(cfg_q);
    end
  end

  assign out_free   = !ov_q || res_ready_i;
  assign s1_fire    = s1_v_q && out_free;
  assign in_ready_o = !clr_q && (!s1_v_q || out_free);
  assign in_fire    = in_valid_i && in_ready_o;

  // position of the incoming pixel
  always_comb begin
    if (frame_start_i) begin
      cur_col = '0;
      cur_row = '0;
    end else begin
      cur_col = ({1'b0, col_q} >= eff_width) ? '0 : col_q;
      cur_row = row_q;
    end
    col_inc = {1'b0, cur_col} + (ColW+1)'(1);
    if (col_inc >= eff_width) begin
      col_d = '0;
      row_d = (cur_row < 2'd2) ? cur_row + 2'd1 : cur_row;
    end else begin
      col_d = col_inc[ColW-1:0];
      row_d = cur_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= FrameWidthRst;
      col_q      <= '0;
      row_q      <= '0;
      s1_v_q     <= 1'b0;
      ov_q       <= 1'b0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + ColW'(1);
        if (clr_addr_q == ColW'(MaxWidth - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (in_fire) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (in_ready_o) begin
        s1_v_q <= in_valid_i;
      end
      if (out_free) begin
        ov_q <= s1_v_q;
      end
    end
  end

  // first stage payload and line store reads
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mag_q    <= grad_magnitude_i;
      s1_ang_q    <= grad_angle_i;
      s1_col_q    <= cur_col;
      s1_center_q <= (cur_row == 2'd2) || (cur_row == 2'd1 && cur_col != '0);
      s1_border_q <= (cur_col <= ColW'(1)) || (cur_row == 2'd1);
      prev_rd_q   <= prev_mem[cur_col];
      older_rd_q  <= older_mem[cur_col];
      angr_rd_q   <= ang_mem[cur_col];
    end
  end

  // line store writes follow the item out of the first stage
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      prev_mem[clr_addr_q]  <= '0;
      older_mem[clr_addr_q] <= '0;
      ang_mem[clr_addr_q]   <= '0;
    end else if (s1_fire) begin
      prev_mem[s1_col_q]  <= s1_mag_q;
      older_mem[s1_col_q] <= prev_rd_q;
      ang_mem[s1_col_q]   <= s1_ang_q;
    end
  end

  // shifted window: top row oldest, right column newest
  always_comb begin
    win_d[0] = win_q[1];
    win_d[1] = win_q[2];
    win_d[2] = older_rd_q;
    win_d[3] = win_q[4];
    win_d[4] = win_q[5];
    win_d[5] = prev_rd_q;
    win_d[6] = win_q[7];
    win_d[7] = win_q[8];
    win_d[8] = s1_mag_q;
  end

  assign sector = angle_sector(center_ang_q);

  always_comb begin
    unique case (sector)
      SecHoriz: begin
        nb_a = win_d[3];
        nb_b = win_d[5];
      end
      SecDiagR: begin
        nb_a = win_d[0];
        nb_b = win_d[8];
      end
      SecVert: begin
        nb_a = win_d[1];
        nb_b = win_d[7];
      end
      SecDiagL: begin
        nb_a = win_d[6];
        nb_b = win_d[2];
      end
      default: begin
        nb_a = win_d[3];
        nb_b = win_d[5];
      end
    endcase
    if (s1_center_q && !s1_border_q && win_d[4] >= nb_a && win_d[4] >= nb_b) begin
      kept = win_d[4];
    end else begin
      kept = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      win_q        <= win_d;
      center_ang_q <= angr_rd_q;
      kept_q       <= kept;
      outv_q       <= s1_center_q;
    end
  end

  assign res_valid_o      = ov_q;
  assign kept_magnitude_o = kept_q;
  assign out_valid_o      = outv_q;

endmodule

`default_nettype wire

@@ src/enms_checker.sv @@
// enms_checker: port-level assertions for edge_non_maximum_suppression, bound to the top
`default_nettype none

module enms_checker
  import enms_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             res_valid_o,
  input wire logic             res_ready_i,
  input wire logic [MagW-1:0]  kept_magnitude_o,
  input wire logic             out_valid_o
);

  // a draining output always leaves room for a new pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i) |-> in_ready_o)
    else $error("in_ready_o low while the output drains");

  // a result with no center carries zero magnitude
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !out_valid_o) |-> (kept_magnitude_o == '0))
    else $error("no-center result with nonzero magnitude");

  // a newly shown result traces back through the first stage to a pixel transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result appeared without a matching pixel transfer");

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=>
      (res_valid_o && $stable(kept_magnitude_o) && $stable(out_valid_o)))
    else $error("stalled result changed or vanished");

endmodule

bind edge_non_maximum_suppression enms_checker u_enms_checker (.*);

`default_nettype wire

@@ dv/edge_non_maximum_suppression_tb.sv @@
// edge_non_maximum_suppression_tb: self-checking bench for the streaming 3x3 edge suppression
module edge_non_maximum_suppression_tb;
  import enms_pkg::*;

  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic fs;
    mag_t mag;
    ang_t ang;
  } pixel_t;

  typedef struct packed {
    mag_t kept;
    logic shown;
  } result_t;

  // directed rows: typed = 1 means the result below is read off directly
  typedef struct packed {
    logic    fs;
    mag_t    mag;
    ang_t    ang;
    logic    typed;
    mag_t    kept;
    logic    shown;
  } stim_row_t;

  logic            clk_i            = 1'b0;
  logic            rst_ni           = 1'b0;
  logic            cfg_we_i         = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i      = '0;
  logic            in_valid_i       = 1'b0;
  logic            in_ready_o;
  mag_t            grad_magnitude_i = '0;
  ang_t            grad_angle_i     = '0;
  logic            frame_start_i    = 1'b0;
  logic            res_valid_o;
  logic            res_ready_i      = 1'b0;
  mag_t            kept_magnitude_o;
  logic            out_valid_o;

  edge_non_maximum_suppression dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .grad_magnitude_i (grad_magnitude_i),
    .grad_angle_i     (grad_angle_i),
    .frame_start_i    (frame_start_i),
    .res_valid_o      (res_valid_o),
    .res_ready_i      (res_ready_i),
    .kept_magnitude_o (kept_magnitude_o),
    .out_valid_o      (out_valid_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // suppression state mirror
  logic [CfgW-1:0] cfg_width = FrameWidthRst;
  mag_t prev_row  [MaxWidth] = '{default: '0};
  mag_t older_row [MaxWidth] = '{default: '0};
  ang_t angle_row [MaxWidth] = '{default: '0};
  mag_t nbhd      [9]        = '{default: '0};
  ang_t ctr_angle = '0;
  int   col_pos   = 0;
  int   row_pos   = 0;

  result_t pending_q [$];
  int      mismatch_count = 0;
  int      idle_pct       = 19;
  int      cycle_count    = 0;

  ang_t sector_bounds [13] = '{0, 225, 675, 1125, 1575, 1800, 2025, 2475, 2925, 3375,
                               3599, 3600, 4095};

  stim_row_t directed_rows [23] = '{
    '{1, 255,    0, 1, 0, 0},
    '{0,   0, 4095, 1, 0, 0},
    // width 3 frame from here on
    '{1,  10,    0, 1, 0, 0},
    '{0,  20,  900, 1, 0, 0},
    '{0,  30,    0, 1, 0, 0},
    '{0,  40,    0, 1, 0, 0},
    '{0, 255, 1800, 1, 0, 1},
    '{0,  50,    0, 1, 0, 1},
    '{0,   0,    0, 1, 0, 1},
    '{0, 100, 1125, 1, 0, 1},
    '{0, 255,    0, 0, 0, 0},
    '{0, 100,    0, 1, 0, 1},
    '{0,   7, 1575, 1, 0, 1},
    '{0, 100,    0, 0, 0, 0},
    '{0,   7,    0, 1, 0, 1},
    '{0, 200, 4095, 1, 0, 1},
    '{0,   0,    0, 0, 0, 0},
    '{0, 200,    0, 1, 0, 1},
    '{0, 200, 3599, 1, 0, 1},
    '{0, 200,    0, 0, 0, 0},
    '{0, 255,    0, 1, 0, 1},
    '{0, 255,    0, 1, 0, 1},
    '{0, 255,    0, 0, 0, 0}
  };

  function automatic int clamp_width(input logic [CfgW-1:0] v);
    if (v < MinWidth) return MinWidth;
    if (v > MaxWidth) return MaxWidth;
    return int'(v);
  endfunction

  // fold to (-1800,1800] tenths and pick the gradient direction
  function automatic sector_e direction_of(input ang_t raw);
    int a;
    a = int'(raw);
    if (a > 1800) a -= 3600;
    if ((a > -225 && a <= 225) || a > 1575 || a <= -1575) return SecHoriz;
    if ((a > -675 && a <= -225) || (a > 1125 && a <= 1575)) return SecDiagR;
    if ((a > -1125 && a <= -675) || (a > 675 && a <= 1125)) return SecVert;
    return SecDiagL;
  endfunction

  function automatic result_t suppress_pixel(input pixel_t px);
    int      w;
    int      c;
    logic    on_border;
    mag_t    n1;
    mag_t    n2;
    result_t res;
    w = clamp_width(cfg_width);
    if (px.fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    c = col_pos;
    for (int k = 0; k < 3; k++) begin
      nbhd[k*3]   = nbhd[k*3+1];
      nbhd[k*3+1] = nbhd[k*3+2];
    end
    nbhd[2] = older_row[c];
    nbhd[5] = prev_row[c];
    nbhd[8] = px.mag;
    res.shown = (row_pos >= 2) || (row_pos == 1 && c >= 1);
    on_border = (c <= 1) || (row_pos == 1);
    res.kept  = '0;
    if (res.shown && !on_border) begin
      case (direction_of(ctr_angle))
        SecHoriz: begin n1 = nbhd[3]; n2 = nbhd[5]; end
        SecDiagR: begin n1 = nbhd[0]; n2 = nbhd[8]; end
        SecVert:  begin n1 = nbhd[1]; n2 = nbhd[7]; end
        default:  begin n1 = nbhd[6]; n2 = nbhd[2]; end
      endcase
      if (nbhd[4] >= n1 && nbhd[4] >= n2) res.kept = nbhd[4];
    end
    ctr_angle    = angle_row[c];
    older_row[c] = prev_row[c];
    prev_row[c]  = px.mag;
    angle_row[c] = px.ang;
    if (c + 1 >= w) begin
      col_pos = 0;
      if (row_pos < 2) row_pos++;
    end else begin
      col_pos = c + 1;
    end
    return res;
  endfunction

  function automatic mag_t rand_mag();
    case ($urandom_range(3))
      0:       return mag_t'($urandom_range(0, 3));
      1:       return mag_t'($urandom_range(252, 255));
      default: return mag_t'($urandom_range(0, 255));
    endcase
  endfunction

  // lean on sector boundaries so both sides of each bound get hit
  function automatic ang_t rand_ang();
    case ($urandom_range(9))
      0, 1, 2, 3: return ang_t'(sector_bounds[$urandom_range(12)]
                                + ang_t'($urandom_range(0, 2)) - 1);
      4:          return ang_t'($urandom_range(0, 3599));
      default:    return ang_t'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic push_pixel(input pixel_t px, input logic typed, input result_t fixed);
    result_t want;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    frame_start_i    <= px.fs;
    grad_magnitude_i <= px.mag;
    grad_angle_i     <= px.ang;
    do @(posedge clk_i); while (!in_ready_o);
    want = suppress_pixel(px);
    pending_q.push_back(typed ? fixed : want);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_q.size() != 0);
  endtask

  task automatic set_width(input logic [CfgW-1:0] wdata);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= wdata;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    cfg_width = wdata;
  endtask

  // frames of frame_len pixels, with a rare random frame start; lead controls whether the phase opens a new frame
  task automatic run_phase(input logic [CfgW-1:0] wcfg, input int frame_len, input int n,
                           input bit lead, input bit hold_mid);
    pixel_t px;
    set_width(wcfg);
    for (int p = 0; p < n; p++) begin
      if (hold_mid && p == n / 2) drain_results();
      px.fs  = ((p % frame_len == 0) && (p != 0 || lead)) || ($urandom_range(299) == 0);
      px.mag = rand_mag();
      px.ang = rand_ang();
      push_pixel(px, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (res_valid_o && res_ready_i) begin
        if (pending_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected transfer: kept %0d out_valid %0b", kept_magnitude_o,
                     out_valid_o);
        end else begin
          want = pending_q.pop_front();
          if (kept_magnitude_o !== want.kept || out_valid_o !== want.shown) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch: kept exp %0d got %0d, out_valid exp %0b got %0b",
                       want.kept, kept_magnitude_o, want.shown, out_valid_o);
          end
        end
      end
      res_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    pixel_t          px;
    result_t         fixed;
    logic [CfgW-1:0] wcfg;
    int              w;
    int              frame_len;
    int              n;
    int              sent;
    int              phase_idx;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (i == 2) set_width(CfgW'(3));
      px.fs       = directed_rows[i].fs;
      px.mag      = directed_rows[i].mag;
      px.ang      = directed_rows[i].ang;
      fixed.kept  = directed_rows[i].kept;
      fixed.shown = directed_rows[i].shown;
      push_pixel(px, directed_rows[i].typed, fixed);
    end

    // small widths first, the clamped ones among them
    sent      = 0;
    phase_idx = 0;
    while (sent < 450 || phase_idx < 6) begin
      if (phase_idx < 3) wcfg = CfgW'(phase_idx);
      else if ($urandom_range(5) == 0) wcfg = CfgW'($urandom_range(0, 3));
      else wcfg = CfgW'($urandom_range(3, 24));
      w         = clamp_width(wcfg);
      frame_len = w * $urandom_range(2, 8);
      n         = frame_len * $urandom_range(1, 2) + $urandom_range(0, w);
      if (phase_idx == 3) n = 240;
      idle_pct = (phase_idx == 3) ? 0 : 19;
      run_phase(wcfg, frame_len, n, (phase_idx == 0) || ($urandom_range(9) != 0),
                phase_idx == 5);
      sent += n;
      phase_idx++;
    end

    idle_pct = 19;
    // over-range widths act as the full row; the second continues the same frame
    run_phase('1, 3 * MaxWidth, MaxWidth + 40, 1'b1, 1'b0);
    run_phase(CfgW'(MaxWidth + 1), 3 * MaxWidth, 60, 1'b0, 1'b0);
    run_phase(CfgW'(5), 15, 45, 1'b1, 1'b0);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ edge_non_maximum_suppression.f @@
src/enms_pkg.sv
src/edge_non_maximum_suppression.sv
src/enms_checker.sv
dv/edge_non_maximum_suppression_tb.sv
